/* hdl/bnf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the binary image neighbourhood fetch block.
// Used by every module in hdl/; depends on nothing else.
package bnf_pkg;

    localparam int DEF_ROWS    = 64;
    localparam int DEF_COLS    = 64;
    localparam int COORD_W     = 6;
    localparam int NB_W        = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Window row and column counters run 0..2.
    localparam logic [1:0] TAP_LAST = 2'd2;

    localparam logic KIND_PIX = 1'b0;
    localparam logic KIND_NBH = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_READ_PIX = 2'd1,
        OP_READ_NBH = 2'd2,
        OP_RSVD     = 2'd3
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               pixel_value;
    } req_t;

    typedef struct packed {
        logic            result_kind;
        logic            pixel;
        logic [NB_W-1:0] neighborhood;
        logic            coordinate_error;
    } res_t;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_PIX     = 3'd1,
        CMD_NBH     = 3'd2,
        CMD_ERR_PIX = 3'd3,
        CMD_ERR_NBH = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_PIX     = 3'd2,
        ST_GATHER  = 3'd3,
        ST_NB_DONE = 3'd4
    } back_state_t;

    // Only coordinates that the request fields can carry are ever stored.
    function automatic int eff_dim(input int dim);
        return (dim < (1 << COORD_W)) ? dim : (1 << COORD_W);
    endfunction

endpackage

/* hdl/bnf_front.sv */
`timescale 1ns / 1ps
// Request front end: takes beats from the command port, checks coordinates and
// classifies each request into a queue command. Depends on bnf_pkg.
module bnf_front #(
    parameter int ROWS = bnf_pkg::DEF_ROWS,
    parameter int COLS = bnf_pkg::DEF_COLS
) (
    input  logic                 start,
    input  bnf_pkg::req_t        request,
    input  logic                 clearing,
    input  bnf_pkg::queue_stat_t q_stat,
    output logic                 busy,
    output logic                 push,
    output bnf_pkg::cmd_t        cmd
);

    localparam int EXT_W = bnf_pkg::COORD_W + 1;
    localparam logic [EXT_W-1:0] ROW_LIM = EXT_W'(bnf_pkg::eff_dim(ROWS));
    localparam logic [EXT_W-1:0] COL_LIM = EXT_W'(bnf_pkg::eff_dim(COLS));

    logic bad;
    logic keep;

    assign busy = clearing || q_stat.full;
    assign bad  = ({1'b0, request.row} >= ROW_LIM) || ({1'b0, request.col} >= COL_LIM);

    always_comb
    begin
        cmd.row   = request.row;
        cmd.col   = request.col;
        cmd.value = request.pixel_value;
        cmd.kind  = bnf_pkg::CMD_WRITE;
        keep      = 1'b0;
        unique case (request.operation)
            bnf_pkg::OP_WRITE:
            begin
                cmd.kind = bnf_pkg::CMD_WRITE;
                keep     = !bad;
            end
            bnf_pkg::OP_READ_PIX:
            begin
                cmd.kind = bad ? bnf_pkg::CMD_ERR_PIX : bnf_pkg::CMD_PIX;
                keep     = 1'b1;
            end
            bnf_pkg::OP_READ_NBH:
            begin
                cmd.kind = bad ? bnf_pkg::CMD_ERR_NBH : bnf_pkg::CMD_NBH;
                keep     = 1'b1;
            end
            bnf_pkg::OP_RSVD:
            begin
                // The reserved code is taken and dropped without effect.
                keep = 1'b0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = start && !busy && keep;

endmodule

/* hdl/bnf_cmd_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the memory sequencer.
// Depends on bnf_pkg for the command type and queue depth.
module bnf_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bnf_pkg::cmd_t        cmd_in,
    input  logic                 pop,
    output bnf_pkg::cmd_t        head,
    output bnf_pkg::queue_stat_t stat
);

    localparam logic [bnf_pkg::QPTR_W-1:0] LAST_SLOT =
        bnf_pkg::QPTR_W'(bnf_pkg::QUEUE_DEPTH - 1);
    localparam logic [bnf_pkg::QCNT_W-1:0] FULL_COUNT =
        bnf_pkg::QCNT_W'(bnf_pkg::QUEUE_DEPTH);

    bnf_pkg::cmd_t                slot_reg [bnf_pkg::QUEUE_DEPTH];
    logic [bnf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bnf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bnf_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign stat.full  = (count_reg == FULL_COUNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* hdl/bnf_back.sv */
`timescale 1ns / 1ps
// Memory sequencer: owns the single-port image memory, clears it after reset
// and carries out queued writes, pixel reads and 3x3 gathers. Depends on bnf_pkg.
module bnf_back #(
    parameter int ROWS = bnf_pkg::DEF_ROWS,
    parameter int COLS = bnf_pkg::DEF_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bnf_pkg::cmd_t        head,
    input  bnf_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 clearing,
    output bnf_pkg::res_t        result,
    output logic                 done
);

    localparam int EFF_ROWS = bnf_pkg::eff_dim(ROWS);
    localparam int EFF_COLS = bnf_pkg::eff_dim(COLS);
    localparam int DEPTH    = EFF_ROWS * EFF_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int EXT_W    = bnf_pkg::COORD_W + 1;
    localparam int NB_W     = bnf_pkg::NB_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(EFF_COLS);
    localparam logic [EXT_W-1:0]  ROW_LIM   = EXT_W'(EFF_ROWS);
    localparam logic [EXT_W-1:0]  COL_LIM   = EXT_W'(EFF_COLS);

    bnf_pkg::back_state_t state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    bnf_pkg::cmd_t        cmd_reg, cmd_next;
    logic [1:0]           tap_r_reg, tap_r_next;
    logic [1:0]           tap_c_reg, tap_c_next;
    logic                 pend_in_reg, pend_in_next;
    logic [NB_W-1:0]      nb_reg, nb_next;
    bnf_pkg::res_t        result_reg, result_next;
    logic                 done_reg, done_next;

    logic                 image_mem [DEPTH];
    logic                 rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_wdata;

    logic [ADDR_W-1:0]    head_addr;
    logic [EXT_W-1:0]     tap_row, tap_col;
    logic [EXT_W-1:0]     tap_rsel, tap_csel;
    logic                 tap_in;
    logic [ADDR_W-1:0]    tap_addr;
    logic                 tap_bit;

    assign head_addr = ADDR_W'(ADDR_W'(head.row) * COLS_A) + ADDR_W'(head.col);

    // Window coordinates are kept offset by one so the top and left edges stay unsigned.
    assign tap_row  = EXT_W'(cmd_reg.row) + EXT_W'(tap_r_reg);
    assign tap_col  = EXT_W'(cmd_reg.col) + EXT_W'(tap_c_reg);
    assign tap_in   = (tap_row != '0) && (tap_row <= ROW_LIM)
                   && (tap_col != '0) && (tap_col <= COL_LIM);
    assign tap_rsel = tap_row - EXT_W'(1);
    assign tap_csel = tap_col - EXT_W'(1);
    assign tap_addr = ADDR_W'(ADDR_W'(tap_rsel) * COLS_A) + ADDR_W'(tap_csel);

    // Read data is registered and lands in the cycle after the address; taps shift in from the top.
    assign tap_bit = rdata_reg & pend_in_reg;
    assign nb_next = {tap_bit, nb_reg[NB_W-1:1]};

    assign clearing = (state_reg == bnf_pkg::ST_CLEAR);
    assign result   = result_reg;
    assign done     = done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bnf_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = bnf_pkg::ST_IDLE;
                end
            end
            bnf_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (head.kind == bnf_pkg::CMD_PIX)
                    begin
                        state_next = bnf_pkg::ST_PIX;
                    end
                    else if (head.kind == bnf_pkg::CMD_NBH)
                    begin
                        state_next = bnf_pkg::ST_GATHER;
                    end
                end
            end
            bnf_pkg::ST_PIX:
            begin
                state_next = bnf_pkg::ST_IDLE;
            end
            bnf_pkg::ST_GATHER:
            begin
                if ((tap_r_reg == bnf_pkg::TAP_LAST) && (tap_c_reg == bnf_pkg::TAP_LAST))
                begin
                    state_next = bnf_pkg::ST_NB_DONE;
                end
            end
            bnf_pkg::ST_NB_DONE:
            begin
                state_next = bnf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bnf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = head_addr;
        mem_wdata     = 1'b0;
        clr_addr_next = clr_addr_reg;
        cmd_next      = cmd_reg;
        tap_r_next    = tap_r_reg;
        tap_c_next    = tap_c_reg;
        pend_in_next  = 1'b0;
        result_next   = '0;
        done_next     = 1'b0;
        unique case (state_reg)
            bnf_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            bnf_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.kind)
                        bnf_pkg::CMD_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = head.value;
                        end
                        bnf_pkg::CMD_PIX:
                        begin
                            // The read is issued here; data is taken in the next state.
                            mem_we = 1'b0;
                        end
                        bnf_pkg::CMD_NBH:
                        begin
                            tap_r_next = '0;
                            tap_c_next = '0;
                        end
                        bnf_pkg::CMD_ERR_PIX:
                        begin
                            done_next                    = 1'b1;
                            result_next.result_kind      = bnf_pkg::KIND_PIX;
                            result_next.coordinate_error = 1'b1;
                        end
                        bnf_pkg::CMD_ERR_NBH:
                        begin
                            done_next                    = 1'b1;
                            result_next.result_kind      = bnf_pkg::KIND_NBH;
                            result_next.coordinate_error = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            bnf_pkg::ST_PIX:
            begin
                done_next               = 1'b1;
                result_next.result_kind = bnf_pkg::KIND_PIX;
                result_next.pixel       = rdata_reg;
            end
            bnf_pkg::ST_GATHER:
            begin
                mem_addr     = tap_addr;
                pend_in_next = tap_in;
                if (tap_c_reg == bnf_pkg::TAP_LAST)
                begin
                    tap_c_next = '0;
                    tap_r_next = tap_r_reg + 1'b1;
                end
                else
                begin
                    tap_c_next = tap_c_reg + 1'b1;
                end
            end
            bnf_pkg::ST_NB_DONE:
            begin
                done_next                = 1'b1;
                result_next.result_kind  = bnf_pkg::KIND_NBH;
                result_next.neighborhood = nb_next;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bnf_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tap_r_reg   <= tap_r_next;
        tap_c_reg   <= tap_c_next;
        pend_in_reg <= pend_in_next;
        nb_reg      <= nb_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            image_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= image_mem[mem_addr];
    end

endmodule

/* hdl/binary_image_neighborhood_fetch.sv */
`timescale 1ns / 1ps
// Top level of the binary image neighbourhood fetch block.
// Depends on bnf_pkg, bnf_front, bnf_cmd_queue and bnf_back.
//
// A request beat is taken at a rising edge where start is high and busy is
// low. Writes store one bit at (row, col); single reads return that bit; a
// neighbourhood read returns the 3x3 window around (row, col), bit 0 at the
// top-left and the centre at bit 4, with pixels beyond the image reading as
// zero. A read with a coordinate outside the image returns zeros with
// coordinate_error set; such a write, and the reserved operation, do nothing.
// Each result is shown on result for one cycle with done high; the receiver
// cannot stall it, so results are never held back.
// Requests pass through a two-entry command queue to a sequencer that owns a
// single-port image memory. The sequencer takes a command from the queue when
// idle: a write is stored as it is taken, a single read issues its memory read
// and returns the registered read data, a bad-coordinate read returns its
// error result without a memory access, and a neighbourhood read makes one
// memory read per window position before it returns the window. busy rises
// when the queue is full. After reset the memory is cleared one address per
// cycle over all min(ROWS,64) * min(COLS,64) addresses, during which busy
// stays high.
module binary_image_neighborhood_fetch #(
    parameter int ROWS = bnf_pkg::DEF_ROWS,
    parameter int COLS = bnf_pkg::DEF_COLS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bnf_pkg::req_t request,
    output logic          busy,
    output bnf_pkg::res_t result,
    output logic          done
);

    bnf_pkg::queue_stat_t q_stat;
    bnf_pkg::cmd_t        push_cmd;
    bnf_pkg::cmd_t        head_cmd;
    logic                 push;
    logic                 pop;
    logic                 clearing;

    bnf_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .start    (start),
        .request  (request),
        .clearing (clearing),
        .q_stat   (q_stat),
        .busy     (busy),
        .push     (push),
        .cmd      (push_cmd)
    );

    bnf_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (push_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .stat   (q_stat)
    );

    bnf_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .clearing (clearing),
        .result   (result),
        .done     (done)
    );

endmodule
